FILE: hdl/srlf_pkg.sv
// shared types and constants of the stereo linear resampler and framer
package srlf_pkg;

    // fixed field and register widths
    localparam int SAMPLE_W   = 16;
    localparam int STEP_W     = 20;
    localparam int FLEN_W     = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // defaults for the top-level parameters
    localparam int PHASE_FRAC_BITS_DEF = 16;
    localparam int MAX_FRAME_LEN_DEF   = 4096;

    // register reset values
    localparam logic [FLEN_W-1:0] FLEN_RESET = FLEN_W'(480);

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MONO_SOURCE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 2'd2;

    // input item: one stereo frame
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } srlf_in_t;

    // result item: one interpolated frame plus mix and frame mark
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
        logic signed [SAMPLE_W-1:0] mono_out;
        logic                       frame_end;
    } srlf_out_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the incoming frame as current
        logic prime;    // load the incoming frame as history
        logic mul;      // form the interpolation products
        logic emit;     // write a result item, advance phase and fill
        logic finish;   // drop phase by one, current becomes history
    } srlf_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic step_zero;
        logic hist_valid;
        logic phase_ge_one;
        logic out_stall;
    } srlf_stat_t;

endpackage

FILE: hdl/srlf_ctrl.sv
// sequencing state machine of the resampler
module srlf_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  srlf_pkg::srlf_stat_t stat,
    output srlf_pkg::srlf_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;
    logic   accept;

    assign accept  = s_valid && s_ready_reg;
    assign s_ready = s_ready_reg;

    // next state and commands
    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept && !stat.step_zero) begin
                    if (!stat.hist_valid) begin
                        cmd.prime = 1'b1;
                    end else begin
                        cmd.capture = 1'b1;
                        state_next  = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (stat.phase_ge_one) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!stat.out_stall) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        s_ready_next = (state_next == ST_IDLE);
    end

    // state and registered ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
        end
    end

    // a result is never written over one that is still waiting
    a_emit_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !stat.out_stall)
        else $error("emit while output item still waiting");

    // priming leaves the history valid
    a_prime_sets_hist: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.prime |=> stat.hist_valid)
        else $error("history not valid after prime");

    // products are only formed for a phase below one
    a_mul_phase_low: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul |-> !stat.phase_ge_one)
        else $error("interpolation with phase at or above one");

    // no item is taken while one is still being worked on
    a_accept_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> !(cmd.mul || cmd.emit || cmd.finish))
        else $error("item accepted while busy");

endmodule

FILE: hdl/srlf_dpath.sv
// registers, interpolation arithmetic, phase and frame counters of the resampler
module srlf_dpath #(
    parameter int PHASE_FRAC_BITS = srlf_pkg::PHASE_FRAC_BITS_DEF,
    parameter int MAX_FRAME_LEN   = srlf_pkg::MAX_FRAME_LEN_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [srlf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [srlf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  srlf_pkg::srlf_in_t                  s_data,
    input  srlf_pkg::srlf_cmd_t                 cmd,
    output srlf_pkg::srlf_stat_t                stat,
    input  logic                                m_ready,
    output logic                                m_valid,
    output srlf_pkg::srlf_out_t                 m_data
);

    localparam int P      = PHASE_FRAC_BITS;
    localparam int SW     = srlf_pkg::SAMPLE_W;
    localparam int DW     = SW + 1;
    localparam int PH_W   = ((P > srlf_pkg::STEP_W) ? P : srlf_pkg::STEP_W) + 1;
    localparam int PROD_W = DW + P + 1;
    localparam int FILL_W = $clog2(MAX_FRAME_LEN);
    localparam int MAXL_W = $clog2(MAX_FRAME_LEN + 1);
    localparam int LEN_W  = (MAXL_W > srlf_pkg::FLEN_W) ? MAXL_W : srlf_pkg::FLEN_W;

    localparam logic [PH_W-1:0]  PHASE_ONE = PH_W'(1) << P;
    localparam logic [PH_W-1:0]  MIN_STEP  = PH_W'(1) << (P - 3);
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_FRAME_LEN);
    localparam logic [LEN_W-1:0] LEN_ONE   = LEN_W'(1);

    // configuration registers
    logic [srlf_pkg::STEP_W-1:0] phase_step_reg;
    logic                        mono_source_reg;
    logic [srlf_pkg::FLEN_W-1:0] frame_length_reg;

    // history, current frame, phase and fill
    logic signed [SW-1:0] prev_l_reg, prev_r_reg;
    logic signed [SW-1:0] cur_l_reg, cur_r_reg;
    logic                 hist_valid_reg;
    logic [PH_W-1:0]      phase_reg;
    logic [FILL_W-1:0]    fill_reg;

    // product registers
    logic signed [PROD_W-1:0] prod_l_reg, prod_r_reg;

    // output register
    logic                m_valid_reg;
    srlf_pkg::srlf_out_t m_data_reg;

    logic signed [SW-1:0]     in_r;
    logic [PH_W-1:0]          step_ext, step_eff;
    logic [LEN_W-1:0]         len_ext, len_eff, fill_inc;
    logic                     frame_done;
    logic signed [DW-1:0]     diff_l, diff_r;
    logic signed [P:0]        frac_s;
    logic signed [PROD_W-1:0] sh_l, sh_r;
    logic signed [DW-1:0]     sum_l, sum_r, mix;
    logic signed [SW-1:0]     res_l, res_r;

    // mono source copies left into right
    assign in_r = mono_source_reg ? s_data.left_sample : s_data.right_sample;

    // effective step, raised to one eighth
    assign step_ext = PH_W'(phase_step_reg);
    assign step_eff = (step_ext < MIN_STEP) ? MIN_STEP : step_ext;

    // effective frame length, clamped to one and the maximum
    assign len_ext = LEN_W'(frame_length_reg);
    always_comb begin
        if (len_ext == '0) begin
            len_eff = LEN_ONE;
        end else if (len_ext > LEN_MAX) begin
            len_eff = LEN_MAX;
        end else begin
            len_eff = len_ext;
        end
    end
    assign fill_inc   = LEN_W'(fill_reg) + LEN_ONE;
    assign frame_done = (fill_inc >= len_eff);

    // differences and fraction for the multipliers
    assign diff_l = DW'(cur_l_reg) - DW'(prev_l_reg);
    assign diff_r = DW'(cur_r_reg) - DW'(prev_r_reg);
    assign frac_s = signed'({1'b0, phase_reg[P-1:0]});

    // floor shift of the products, add back history, mono mix
    assign sh_l  = prod_l_reg >>> P;
    assign sh_r  = prod_r_reg >>> P;
    assign sum_l = DW'(prev_l_reg) + sh_l[DW-1:0];
    assign sum_r = DW'(prev_r_reg) + sh_r[DW-1:0];
    assign res_l = sum_l[SW-1:0];
    assign res_r = sum_r[SW-1:0];
    assign mix   = DW'(res_l) + DW'(res_r);

    // status to the controller
    assign stat.step_zero    = (phase_step_reg == '0);
    assign stat.hist_valid   = hist_valid_reg;
    assign stat.phase_ge_one = (phase_reg >= PHASE_ONE);
    assign stat.out_stall    = m_valid_reg && !m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg   <= '0;
            mono_source_reg  <= 1'b0;
            frame_length_reg <= srlf_pkg::FLEN_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                srlf_pkg::REG_PHASE_STEP:   phase_step_reg   <= cfg_wdata[srlf_pkg::STEP_W-1:0];
                srlf_pkg::REG_MONO_SOURCE:  mono_source_reg  <= cfg_wdata[0];
                srlf_pkg::REG_FRAME_LENGTH: frame_length_reg <= cfg_wdata[srlf_pkg::FLEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // history, phase and fill control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_l_reg     <= '0;
            prev_r_reg     <= '0;
            hist_valid_reg <= 1'b0;
            phase_reg      <= '0;
            fill_reg       <= '0;
        end else begin
            if (cmd.prime) begin
                prev_l_reg     <= s_data.left_sample;
                prev_r_reg     <= in_r;
                hist_valid_reg <= 1'b1;
            end
            if (cmd.finish) begin
                prev_l_reg <= cur_l_reg;
                prev_r_reg <= cur_r_reg;
                phase_reg  <= phase_reg - PHASE_ONE;
            end
            if (cmd.emit) begin
                phase_reg <= phase_reg + step_eff;
                fill_reg  <= frame_done ? '0 : fill_inc[FILL_W-1:0];
            end
        end
    end

    // current frame and products
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cur_l_reg <= s_data.left_sample;
            cur_r_reg <= in_r;
        end
        if (cmd.mul) begin
            prod_l_reg <= PROD_W'(diff_l * frac_s);
            prod_r_reg <= PROD_W'(diff_r * frac_s);
        end
    end

    // output item register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg.left_out  <= res_l;
            m_data_reg.right_out <= res_r;
            m_data_reg.mono_out  <= mix[DW-1:1];
            m_data_reg.frame_end <= frame_done;
        end
    end

endmodule

FILE: hdl/stereo_linear_resampler_framer_unit.sv
// top level of the stereo linear resampler and framer
//
// Linear-interpolation sample rate converter for stereo Q1.15 frames. Each accepted
// item is one input frame; after the first frame (which only loads the history) it
// yields zero to eight result items, each an interpolated stereo sample with its mono
// mix and a mark on the last sample of every output frame of frame_length samples.
// A phase_step of zero drops items. For each result the sequencer runs its check,
// multiply and emit steps, waiting in emit while the last result is still held;
// a final check retires the item, and no new item is taken before that. The output
// register holds a finished result while the next item is taken.
module stereo_linear_resampler_framer_unit #(
    parameter int PHASE_FRAC_BITS = srlf_pkg::PHASE_FRAC_BITS_DEF,
    parameter int MAX_FRAME_LEN   = srlf_pkg::MAX_FRAME_LEN_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [srlf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srlf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  srlf_pkg::srlf_in_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output srlf_pkg::srlf_out_t             m_data
);

    srlf_pkg::srlf_cmd_t  cmd;
    srlf_pkg::srlf_stat_t stat;

    // sequencer
    srlf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // arithmetic and state
    srlf_dpath #(
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS),
        .MAX_FRAME_LEN   (MAX_FRAME_LEN)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

endmodule
